FILE: sv/fbprc_pkg.sv
// Shared types and constants for the flat bad pixel row classifier.
`default_nettype none

package fbprc_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_WIDTH      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_THRESHOLD  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_THRESHOLD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_BAD        = 2'd3;

   // Width of the row width register, the bad count and its limit.
   localparam int COUNT_W = 12;

   // Pixel values and thresholds are signed Q16.16.
   localparam int PIXEL_W = 32;

   // Register reset values.
   localparam logic [COUNT_W-1:0]        ROW_WIDTH_RESET = 12'd2048;
   localparam logic signed [PIXEL_W-1:0] LOW_THR_RESET   = 32'sd32768;
   localparam logic signed [PIXEL_W-1:0] HIGH_THR_RESET  = 32'sd131072;
   localparam logic [COUNT_W-1:0]        MAX_BAD_RESET   = 12'd2048;

   // Saturation value of the per-row bad count.
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Per-pixel classification as held in the row store.
   typedef struct packed {
      logic order;
      logic flat;
   } mark_type;

endpackage

`default_nettype wire

FILE: sv/fbprc_pixel_class.sv
// Per-pixel classification against the flat thresholds.
`default_nettype none

module fbprc_pixel_class (
   input  logic                                  is_nan,
   input  logic                                  is_infinite,
   input  logic signed [fbprc_pkg::PIXEL_W-1:0]  pixel_value,
   input  logic signed [fbprc_pkg::PIXEL_W-1:0]  low_threshold,
   input  logic signed [fbprc_pkg::PIXEL_W-1:0]  high_threshold,
   output fbprc_pkg::mark_type                   mark
);
   import fbprc_pkg::*;

   logic below_low;
   logic above_high;

   assign below_low  = pixel_value < low_threshold;
   assign above_high = pixel_value > high_threshold;

   // An infinite pixel gets no mark, even when it is also flagged as NaN.
   always_comb begin
      mark = '0;
      priority if (is_infinite) begin
         mark = '0;
      end else if (is_nan) begin
         mark.order = 1'b1;
      end else begin
         mark.flat = below_low | above_high;
      end
   end

endmodule

`default_nettype wire

FILE: sv/flat_bad_pixel_row_classifier_top.sv
// Top level of the flat bad pixel row classifier: row store, counters and result register.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_mode, req_pixel_value, req_is_nan,
//                                              req_is_infinite
//   rsp      out        rsp_valid / rsp_ready  rsp_flat_bad, rsp_out_of_order, rsp_row_last
//   csr      in         csr_we                 csr_index, csr_wdata
//
// One request is taken per cycle; its result, if any, shows in the next cycle from the
// result register fed by the registered read port of the row store.
// The row store is read and written at the same address in the same cycle, read first.
// Reset clears the counters and the pending row flags; the row store is not cleared.
// A result that is not taken stalls the request side until it is taken.
`default_nettype none

module flat_bad_pixel_row_classifier_top #(
   parameter int MAX_ROW_WIDTH = 2048
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_mode,
   input  logic signed [fbprc_pkg::PIXEL_W-1:0]  req_pixel_value,
   input  logic                                  req_is_nan,
   input  logic                                  req_is_infinite,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_flat_bad,
   output logic                                  rsp_out_of_order,
   output logic                                  rsp_row_last,

   input  logic                                  csr_we,
   input  logic [fbprc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fbprc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import fbprc_pkg::*;

   localparam int COL_W = $clog2(MAX_ROW_WIDTH);
   localparam int CMP_W = ((COL_W > COUNT_W) ? COL_W : COUNT_W) + 1;

   // Configuration registers.
   logic [COUNT_W-1:0]        row_width_ff;
   logic signed [PIXEL_W-1:0] low_thr_ff;
   logic signed [PIXEL_W-1:0] high_thr_ff;
   logic [COUNT_W-1:0]        max_bad_ff;

   // Row state.
   logic [COL_W-1:0]   write_col_ff, write_col_in;
   logic [COL_W-1:0]   drain_col_ff, drain_col_in;
   logic [COUNT_W-1:0] bad_count_ff, bad_count_in;
   logic               pend_clr_ff, pend_clr_in;
   logic               pend_valid_ff, pend_valid_in;

   // Result register.
   logic     rsp_valid_ff;
   logic     rsp_last_ff, rsp_last_in;
   logic     rsp_clr_ff;
   mark_type rd_data_ff;

   // Row store.
   mark_type row_store [MAX_ROW_WIDTH];

   logic               req_accept;
   logic               emit_in;
   logic               store_we;
   logic [COL_W-1:0]   rd_addr;
   mark_type           pixel_mark;
   logic [CMP_W-1:0]   width_ext;
   logic [CMP_W-1:0]   width_eff;
   logic [CMP_W-1:0]   last_col;
   logic               write_last;
   logic               drain_last;
   logic               pend_eff;
   logic               drain_ok;
   logic [COUNT_W-1:0] bad_count_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         low_thr_ff   <= LOW_THR_RESET;
         high_thr_ff  <= HIGH_THR_RESET;
         max_bad_ff   <= MAX_BAD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ROW_WIDTH:      row_width_ff <= csr_wdata[COUNT_W-1:0];
            REG_LOW_THRESHOLD:  low_thr_ff   <= signed'(csr_wdata[PIXEL_W-1:0]);
            REG_HIGH_THRESHOLD: high_thr_ff  <= signed'(csr_wdata[PIXEL_W-1:0]);
            REG_MAX_BAD:        max_bad_ff   <= csr_wdata[COUNT_W-1:0];
         endcase
      end
   end

   // Width in use: zero acts as one, anything above the store depth as the depth.
   assign width_ext = CMP_W'(row_width_ff);

   always_comb begin
      priority if (width_ext == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_ROW_WIDTH)) begin
         width_eff = CMP_W'(MAX_ROW_WIDTH);
      end else begin
         width_eff = width_ext;
      end
   end

   assign last_col   = width_eff - CMP_W'(1);
   assign write_last = CMP_W'(write_col_ff) >= last_col;
   assign drain_last = CMP_W'(drain_col_ff) >= last_col;

   fbprc_pixel_class u_class (
      .is_nan         (req_is_nan),
      .is_infinite    (req_is_infinite),
      .pixel_value    (req_pixel_value),
      .low_threshold  (low_thr_ff),
      .high_threshold (high_thr_ff),
      .mark           (pixel_mark)
   );

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // A pixel arriving in the middle of a drain drops the rest of the buffered row.
   assign pend_eff = pend_valid_ff && (drain_col_ff == '0);
   // Draining is only possible between rows.
   assign drain_ok = pend_valid_ff && (write_col_ff == '0);

   assign bad_count_next = (pixel_mark.flat && (bad_count_ff != COUNT_MAX)) ?
                           bad_count_ff + COUNT_W'(1) : bad_count_ff;

   always_comb begin
      write_col_in  = write_col_ff;
      drain_col_in  = drain_col_ff;
      bad_count_in  = bad_count_ff;
      pend_clr_in   = pend_clr_ff;
      pend_valid_in = pend_valid_ff;
      emit_in       = 1'b0;
      rsp_last_in   = write_last;
      store_we      = 1'b0;
      rd_addr       = write_col_ff;

      if (req_accept) begin
         if (req_mode) begin
            if (drain_ok) begin
               emit_in     = 1'b1;
               rd_addr     = drain_col_ff;
               rsp_last_in = drain_last;
               if (drain_last) begin
                  pend_valid_in = 1'b0;
                  drain_col_in  = '0;
               end else begin
                  drain_col_in = drain_col_ff + COL_W'(1);
               end
            end
         end else begin
            store_we      = 1'b1;
            emit_in       = pend_eff;
            drain_col_in  = '0;
            pend_valid_in = pend_eff;
            if (write_last) begin
               pend_clr_in   = bad_count_next > max_bad_ff;
               pend_valid_in = 1'b1;
               bad_count_in  = '0;
               write_col_in  = '0;
            end else begin
               bad_count_in = bad_count_next;
               write_col_in = write_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_col_ff  <= '0;
         drain_col_ff  <= '0;
         bad_count_ff  <= '0;
         pend_clr_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         write_col_ff  <= write_col_in;
         drain_col_ff  <= drain_col_in;
         bad_count_ff  <= bad_count_in;
         pend_clr_ff   <= pend_clr_in;
         pend_valid_ff <= pend_valid_in;
         if (req_accept) begin
            rsp_valid_ff <= emit_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // The clear flag is taken before this request may replace it at the end of a row.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_last_ff <= rsp_last_in;
         rsp_clr_ff  <= pend_clr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         row_store[write_col_ff] <= pixel_mark;
      end
      if (req_accept) begin
         rd_data_ff <= row_store[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_flat_bad     = rd_data_ff.flat && !rsp_clr_ff;
   assign rsp_out_of_order = rd_data_ff.order;
   assign rsp_row_last     = rsp_last_ff;

   a_drain_needs_row: assert property (@(posedge clock) disable iff (reset)
      (drain_col_ff != '0) |-> (pend_valid_ff && (write_col_ff == '0)))
      else $error("drain column advanced without a buffered row or during a row");

   a_idle_drain_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode && !pend_valid_ff) |=> !rsp_valid_ff)
      else $error("drain request without a buffered row produced a result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(bad_count_ff) <= CMP_W'(write_col_ff))
      else $error("row bad count exceeds the pixels written in the row");

endmodule

`default_nettype wire
